FILE: hw/rtl/gce_pkg.sv
// ----------------------------------------------------------------------------
// gce_pkg
// Shared widths, codes, item tag type and the decay ROM builder for the
// Gaussian covariance element pipeline.
// ----------------------------------------------------------------------------
package gce_pkg;

	// Table geometry.
	localparam int TABLE_SIZE     = 1024;
	localparam int STEPS_PER_UNIT = 64;
	localparam int ADDR_W         = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

	// Field and datapath widths.
	localparam int COORD_W   = 20;
	localparam int INDEX_W   = 16;
	localparam int REG_W     = 24;
	localparam int FRAC_W    = 16;
	localparam int G_W       = 16;
	localparam int OUT_W     = 40;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int DIST_W    = SQ_W + 1;
	localparam int HI_W      = DIST_W - FRAC_W;
	localparam int POS_W     = HI_W + REG_W;
	localparam int IPOS_W    = POS_W - FRAC_W;
	localparam int CFG_IDX_W = 2;

	// Largest table index that still has a right neighbor to interpolate with.
	localparam logic [IPOS_W-1:0] IDX_LIMIT = IPOS_W'(TABLE_SIZE - 2);

	// Cycles from the accepting edge to the edge that takes the result.
	localparam int PIPE_LATENCY = 14;

	// Request types.
	localparam logic [1:0] REQ_DATA_DATA = 2'd0;
	localparam logic [1:0] REQ_MAP_DATA  = 2'd1;
	localparam logic [1:0] REQ_DATA_MAP  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PERP_SCALE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARA_SCALE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_VARIANCE = 2'd2;

	// Reset value of every configuration register: 1.0 in Q8.16.
	localparam logic [REG_W-1:0] CFG_RESET = 24'd65536;

	// Side information that travels with an item down the pipeline.
	typedef struct packed {
		logic [1:0]       req_type;
		logic             index_eq;
		logic [REG_W-1:0] weight;
	} gce_tag_t;

	// Alternating Taylor series of exp(-1/STEPS_PER_UNIT) in Q0.62.
	localparam logic [63:0] TAY_T0  = 64'd1 << 62;
	localparam logic [63:0] TAY_T1  = TAY_T0  / (64'(STEPS_PER_UNIT) * 64'd1);
	localparam logic [63:0] TAY_T2  = TAY_T1  / (64'(STEPS_PER_UNIT) * 64'd2);
	localparam logic [63:0] TAY_T3  = TAY_T2  / (64'(STEPS_PER_UNIT) * 64'd3);
	localparam logic [63:0] TAY_T4  = TAY_T3  / (64'(STEPS_PER_UNIT) * 64'd4);
	localparam logic [63:0] TAY_T5  = TAY_T4  / (64'(STEPS_PER_UNIT) * 64'd5);
	localparam logic [63:0] TAY_T6  = TAY_T5  / (64'(STEPS_PER_UNIT) * 64'd6);
	localparam logic [63:0] TAY_T7  = TAY_T6  / (64'(STEPS_PER_UNIT) * 64'd7);
	localparam logic [63:0] TAY_T8  = TAY_T7  / (64'(STEPS_PER_UNIT) * 64'd8);
	localparam logic [63:0] TAY_T9  = TAY_T8  / (64'(STEPS_PER_UNIT) * 64'd9);
	localparam logic [63:0] TAY_T10 = TAY_T9  / (64'(STEPS_PER_UNIT) * 64'd10);
	localparam logic [63:0] TAY_T11 = TAY_T10 / (64'(STEPS_PER_UNIT) * 64'd11);
	localparam logic [63:0] TAY_T12 = TAY_T11 / (64'(STEPS_PER_UNIT) * 64'd12);
	localparam logic [63:0] TAY_T13 = TAY_T12 / (64'(STEPS_PER_UNIT) * 64'd13);
	localparam logic [63:0] TAY_T14 = TAY_T13 / (64'(STEPS_PER_UNIT) * 64'd14);
	localparam logic [63:0] TAY_T15 = TAY_T14 / (64'(STEPS_PER_UNIT) * 64'd15);
	localparam logic [63:0] TAY_T16 = TAY_T15 / (64'(STEPS_PER_UNIT) * 64'd16);
	localparam logic [63:0] TAY_T17 = TAY_T16 / (64'(STEPS_PER_UNIT) * 64'd17);
	localparam logic [63:0] TAY_T18 = TAY_T17 / (64'(STEPS_PER_UNIT) * 64'd18);
	localparam logic [63:0] TAY_T19 = TAY_T18 / (64'(STEPS_PER_UNIT) * 64'd19);
	localparam logic [63:0] TAY_T20 = TAY_T19 / (64'(STEPS_PER_UNIT) * 64'd20);
	localparam logic [63:0] TAY_T21 = TAY_T20 / (64'(STEPS_PER_UNIT) * 64'd21);
	localparam logic [63:0] TAY_T22 = TAY_T21 / (64'(STEPS_PER_UNIT) * 64'd22);
	localparam logic [63:0] TAY_T23 = TAY_T22 / (64'(STEPS_PER_UNIT) * 64'd23);
	localparam logic [63:0] TAY_T24 = TAY_T23 / (64'(STEPS_PER_UNIT) * 64'd24);

	localparam logic [63:0] TAY_SUM = TAY_T0 - TAY_T1 + TAY_T2 - TAY_T3 + TAY_T4
		- TAY_T5 + TAY_T6 - TAY_T7 + TAY_T8 - TAY_T9 + TAY_T10 - TAY_T11
		+ TAY_T12 - TAY_T13 + TAY_T14 - TAY_T15 + TAY_T16 - TAY_T17
		+ TAY_T18 - TAY_T19 + TAY_T20 - TAY_T21 + TAY_T22 - TAY_T23 + TAY_T24;

	// Per-step decay factor, rounded half up to Q0.32 and clamped below 1.0.
	localparam logic [63:0] DECAY_RAW  = (TAY_SUM + (64'd1 << 29)) >> 30;
	localparam logic [63:0] DECAY_BASE = (DECAY_RAW > 64'hFFFF_FFFF) ?
		64'hFFFF_FFFF : DECAY_RAW;

	typedef logic [G_W-1:0] decay_rom_t [TABLE_SIZE];

	// Builds the Q0.16 decay table by repeated multiplication in Q0.32.
	function automatic decay_rom_t build_decay_rom();
		decay_rom_t  rom;
		logic [63:0] p;
		logic [63:0] e;
		p = 64'd1 << 32;
		for (int k = 0; k < TABLE_SIZE; k++) begin
			e = (p + 64'd32768) >> 16;
			rom[k] = (e > 64'd65535) ? 16'hFFFF : e[G_W-1:0];
			p = (p * DECAY_BASE + (64'd1 << 31)) >> 32;
		end
		return rom;
	endfunction

endpackage

FILE: hw/rtl/gce_separation.sv
// ----------------------------------------------------------------------------
// gce_separation
// Front stages: coordinate differences, squares and the perpendicular and
// parallel squared separations.
// ----------------------------------------------------------------------------
module gce_separation (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_in,
	input  gce_pkg::gce_tag_t            tag_in,
	input  logic [gce_pkg::COORD_W-1:0]  ax,
	input  logic [gce_pkg::COORD_W-1:0]  ay,
	input  logic [gce_pkg::COORD_W-1:0]  az,
	input  logic [gce_pkg::COORD_W-1:0]  bx,
	input  logic [gce_pkg::COORD_W-1:0]  by,
	input  logic [gce_pkg::COORD_W-1:0]  bz,
	output logic                         valid_out,
	output gce_pkg::gce_tag_t            tag_out,
	output logic [gce_pkg::DIST_W-1:0]   dist_perp,
	output logic [gce_pkg::DIST_W-1:0]   dist_para
);

	function automatic logic [gce_pkg::COORD_W-1:0] abs_diff(
		input logic [gce_pkg::COORD_W-1:0] a,
		input logic [gce_pkg::COORD_W-1:0] b
	);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic                        valid_s1, valid_s2, valid_s3;
	gce_pkg::gce_tag_t           tag_s1, tag_s2, tag_s3;
	logic [gce_pkg::COORD_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [gce_pkg::SQ_W-1:0]    dx2_s2, dy2_s2, dz2_s2;
	logic [gce_pkg::DIST_W-1:0]  perp_s3, para_s3;

	// Valid bits follow the item through the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Differences, then squares, then the sums of squares.
	always_ff @(posedge clk) begin
		tag_s1  <= tag_in;
		dx_s1   <= abs_diff(ax, bx);
		dy_s1   <= abs_diff(ay, by);
		dz_s1   <= abs_diff(az, bz);
		tag_s2  <= tag_s1;
		dx2_s2  <= gce_pkg::SQ_W'(dx_s1) * gce_pkg::SQ_W'(dx_s1);
		dy2_s2  <= gce_pkg::SQ_W'(dy_s1) * gce_pkg::SQ_W'(dy_s1);
		dz2_s2  <= gce_pkg::SQ_W'(dz_s1) * gce_pkg::SQ_W'(dz_s1);
		tag_s3  <= tag_s2;
		perp_s3 <= gce_pkg::DIST_W'(dx2_s2) + gce_pkg::DIST_W'(dy2_s2);
		para_s3 <= gce_pkg::DIST_W'(dz2_s2);
	end

	assign valid_out = valid_s3;
	assign tag_out   = tag_s3;
	assign dist_perp = perp_s3;
	assign dist_para = para_s3;

endmodule

FILE: hw/rtl/gce_decay_rom.sv
// ----------------------------------------------------------------------------
// gce_decay_rom
// Dual-read decay ROM holding exp(-k/STEPS_PER_UNIT) in Q0.16, with
// registered read data.
// ----------------------------------------------------------------------------
module gce_decay_rom (
	input  logic                        clk,
	input  logic [gce_pkg::ADDR_W-1:0]  addr_a,
	input  logic [gce_pkg::ADDR_W-1:0]  addr_b,
	output logic [gce_pkg::G_W-1:0]     data_a,
	output logic [gce_pkg::G_W-1:0]     data_b
);

	localparam gce_pkg::decay_rom_t ROM = gce_pkg::build_decay_rom();

	logic [gce_pkg::G_W-1:0] rd_a_q, rd_b_q;

	// Both ports read in the same cycle.
	always_ff @(posedge clk) begin
		rd_a_q <= ROM[addr_a];
		rd_b_q <= ROM[addr_b];
	end

	assign data_a = rd_a_q;
	assign data_b = rd_b_q;

endmodule

FILE: hw/rtl/gce_lookup.sv
// ----------------------------------------------------------------------------
// gce_lookup
// Scales a squared separation to a table position and interpolates the
// decay table there; positions past the last interval give zero.
// ----------------------------------------------------------------------------
module gce_lookup (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_in,
	input  logic [gce_pkg::DIST_W-1:0]  dist_sq,
	input  logic [gce_pkg::REG_W-1:0]   scale,
	output logic                        valid_out,
	output logic [gce_pkg::G_W-1:0]     g
);

	localparam int LO_W   = gce_pkg::FRAC_W + gce_pkg::REG_W;
	localparam int IP_W   = gce_pkg::G_W + gce_pkg::FRAC_W + 1;
	localparam int ISUM_W = IP_W + 1;
	localparam logic [gce_pkg::FRAC_W:0] ONE_Q = {1'b1, {gce_pkg::FRAC_W{1'b0}}};
	localparam logic [ISUM_W-1:0] ROUND = ISUM_W'(1) << (gce_pkg::FRAC_W - 1);

	logic                       valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic [gce_pkg::POS_W-1:0]  hi_prod_s4;
	logic [gce_pkg::REG_W-1:0]  lo_part_s4;
	logic [gce_pkg::ADDR_W-1:0] idx_s5;
	logic [gce_pkg::FRAC_W-1:0] frac_s5, frac_s6;
	logic                       oor_s5, oor_s6, oor_s7;
	logic [gce_pkg::G_W-1:0]    tbl_lo_s6, tbl_hi_s6;
	logic [IP_W-1:0]            prod0_s7, prod1_s7;
	logic [gce_pkg::G_W-1:0]    g_s8;

	logic [gce_pkg::POS_W-1:0]  hi_prod;
	logic [LO_W-1:0]            lo_prod;
	logic [gce_pkg::POS_W-1:0]  pos;
	logic [gce_pkg::FRAC_W:0]   one_minus;
	logic [ISUM_W-1:0]          interp_sum;

	// Position = dist_sq * scale / 2^16, split into an integer and a fraction part.
	assign hi_prod = gce_pkg::POS_W'(dist_sq[gce_pkg::DIST_W-1:gce_pkg::FRAC_W]) *
		gce_pkg::POS_W'(scale);
	assign lo_prod = LO_W'(dist_sq[gce_pkg::FRAC_W-1:0]) * LO_W'(scale);
	assign pos     = hi_prod_s4 + gce_pkg::POS_W'(lo_part_s4);

	// Interpolation weights and rounded blend.
	assign one_minus  = ONE_Q - {1'b0, frac_s6};
	assign interp_sum = ISUM_W'(prod0_s7) + ISUM_W'(prod1_s7) + ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s4 <= valid_in;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		hi_prod_s4 <= hi_prod;
		lo_part_s4 <= lo_prod[LO_W-1:gce_pkg::FRAC_W];
		idx_s5     <= pos[gce_pkg::FRAC_W +: gce_pkg::ADDR_W];
		frac_s5    <= pos[gce_pkg::FRAC_W-1:0];
		oor_s5     <= (pos[gce_pkg::POS_W-1:gce_pkg::FRAC_W] > gce_pkg::IDX_LIMIT);
		frac_s6    <= frac_s5;
		oor_s6     <= oor_s5;
		prod0_s7   <= IP_W'(tbl_lo_s6) * IP_W'(one_minus);
		prod1_s7   <= IP_W'(tbl_hi_s6) * IP_W'(frac_s6);
		oor_s7     <= oor_s6;
		g_s8       <= oor_s7 ? '0 : interp_sum[gce_pkg::FRAC_W +: gce_pkg::G_W];
	end

	// Left and right neighbors of the position.
	gce_decay_rom u_rom (
		.clk    (clk),
		.addr_a (idx_s5),
		.addr_b (idx_s5 + gce_pkg::ADDR_W'(1)),
		.data_a (tbl_lo_s6),
		.data_b (tbl_hi_s6)
	);

	assign valid_out = valid_s8;
	assign g         = g_s8;

endmodule

FILE: hw/rtl/gce_scale.sv
// ----------------------------------------------------------------------------
// gce_scale
// Back stages: variance times both decay factors, pixel weighting and the
// selection of the covariance value by request type.
// ----------------------------------------------------------------------------
module gce_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_in,
	input  gce_pkg::gce_tag_t           tag_in,
	input  logic [gce_pkg::G_W-1:0]     g_perp,
	input  logic [gce_pkg::G_W-1:0]     g_para,
	input  logic [gce_pkg::REG_W-1:0]   variance,
	output logic                        done,
	output logic [gce_pkg::OUT_W-1:0]   covariance
);

	localparam int VG_W = gce_pkg::REG_W + gce_pkg::G_W;
	localparam int WS_W = 2 * gce_pkg::REG_W;
	localparam logic [WS_W-1:0] ROUND = WS_W'(1) << (gce_pkg::FRAC_W - 1);
	localparam logic [gce_pkg::OUT_W-1:0] ONE_OUT =
		gce_pkg::OUT_W'(1) << gce_pkg::FRAC_W;

	logic                       valid_s9, valid_s10, valid_s11, valid_s12;
	logic                       valid_s13, valid_s14;
	gce_pkg::gce_tag_t          tag_s9, tag_s10, tag_s11, tag_s12, tag_s13;
	logic [VG_W-1:0]            vg_s9, sg_s11;
	logic [gce_pkg::G_W-1:0]    g_para_s9, g_para_s10;
	logic [gce_pkg::REG_W-1:0]  sa_s10, s_s12, s_s13;
	logic [WS_W-1:0]            ws_prod_s13;
	logic [gce_pkg::OUT_W-1:0]  cov_s14;

	logic [VG_W-1:0]                vg_round, sg_round;
	logic [WS_W-1:0]                ws_round;
	logic [WS_W-gce_pkg::FRAC_W-1:0] ws;
	logic [gce_pkg::OUT_W-1:0]      result;

	assign vg_round = vg_s9 + VG_W'(ROUND);
	assign sg_round = sg_s11 + VG_W'(ROUND);
	assign ws_round = ws_prod_s13 + ROUND;
	assign ws       = ws_round[WS_W-1:gce_pkg::FRAC_W];

	// Result by request type. The diagonal value stays below 2^33, so the
	// 40-bit field never reaches its limit.
	always_comb begin
		case (tag_s13.req_type)
			gce_pkg::REQ_DATA_DATA: begin
				result = tag_s13.index_eq ? (gce_pkg::OUT_W'(ws) + ONE_OUT) :
					gce_pkg::OUT_W'(s_s13);
			end
			gce_pkg::REQ_MAP_DATA: begin
				result = gce_pkg::OUT_W'(s_s13);
			end
			gce_pkg::REQ_DATA_MAP: begin
				result = gce_pkg::OUT_W'(ws);
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
		end else begin
			valid_s9  <= valid_in;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
		end
	end

	// Alternating multiply and round stages.
	always_ff @(posedge clk) begin
		tag_s9      <= tag_in;
		vg_s9       <= VG_W'(variance) * VG_W'(g_perp);
		g_para_s9   <= g_para;
		tag_s10     <= tag_s9;
		sa_s10      <= vg_round[gce_pkg::FRAC_W +: gce_pkg::REG_W];
		g_para_s10  <= g_para_s9;
		tag_s11     <= tag_s10;
		sg_s11      <= VG_W'(sa_s10) * VG_W'(g_para_s10);
		tag_s12     <= tag_s11;
		s_s12       <= sg_round[gce_pkg::FRAC_W +: gce_pkg::REG_W];
		tag_s13     <= tag_s12;
		ws_prod_s13 <= WS_W'(tag_s12.weight) * WS_W'(s_s12);
		s_s13       <= s_s12;
		cov_s14     <= result;
	end

	assign done       = valid_s14;
	assign covariance = cov_s14;

endmodule

FILE: hw/rtl/gaussian_covariance_element_core.sv
// ----------------------------------------------------------------------------
// gaussian_covariance_element_core
// Anisotropic Gaussian covariance element: variance * g(perp) * g(para),
// weighted and selected by request type.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the item fields and raise start. An item is taken at every
//   rising edge where start is high and busy is low. busy is always low: the
//   fourteen-stage pipeline takes one item in every cycle.
//   Output: done is high for exactly one cycle with covariance valid. Items
//   leave in the order they arrived, one per cycle at full rate. The pipeline
//   has three separation stages, five lookup stages (scale multiply,
//   position, ROM read, interpolation multiply, blend) and six variance and
//   weighting stages.
//   Configuration: cfg_write, cfg_index and cfg_data write perp_scale (0),
//   para_scale (1) or signal_variance (2); other indexes are ignored. Write
//   only while no item is in flight.
//   Reset: arst_n clears the pipeline valid bits and sets all three
//   registers to 1.0 (Q8.16). The decay table is a ROM and needs no loading.
//   The receiver cannot stall; every result is presented once.
// ----------------------------------------------------------------------------
module gaussian_covariance_element_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [gce_pkg::INDEX_W-1:0]   first_index,
	input  logic [gce_pkg::INDEX_W-1:0]   second_index,
	input  logic [gce_pkg::COORD_W-1:0]   first_x,
	input  logic [gce_pkg::COORD_W-1:0]   first_y,
	input  logic [gce_pkg::COORD_W-1:0]   first_z,
	input  logic [gce_pkg::COORD_W-1:0]   second_x,
	input  logic [gce_pkg::COORD_W-1:0]   second_y,
	input  logic [gce_pkg::COORD_W-1:0]   second_z,
	input  logic [gce_pkg::REG_W-1:0]     pixel_weight,
	input  logic                          cfg_write,
	input  logic [gce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gce_pkg::REG_W-1:0]     cfg_data,
	output logic                          done,
	output logic [gce_pkg::OUT_W-1:0]     covariance
);

	logic [gce_pkg::REG_W-1:0] perp_scale_q, para_scale_q, variance_q;

	gce_pkg::gce_tag_t         tag_in, tag_s3;
	gce_pkg::gce_tag_t         tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic                      accept;
	logic                      valid_s3, valid_perp_s8, valid_para_s8;
	logic [gce_pkg::DIST_W-1:0] dist_perp_s3, dist_para_s3;
	logic [gce_pkg::G_W-1:0]   g_perp_s8, g_para_s8;

	// The pipeline never refuses an item.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign tag_in.req_type = req_type;
	assign tag_in.index_eq = (first_index == second_index);
	assign tag_in.weight   = pixel_weight;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perp_scale_q <= gce_pkg::CFG_RESET;
			para_scale_q <= gce_pkg::CFG_RESET;
			variance_q   <= gce_pkg::CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				gce_pkg::CFG_PERP_SCALE:      perp_scale_q <= cfg_data;
				gce_pkg::CFG_PARA_SCALE:      para_scale_q <= cfg_data;
				gce_pkg::CFG_SIGNAL_VARIANCE: variance_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gce_separation u_sep (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (accept),
		.tag_in    (tag_in),
		.ax        (first_x),
		.ay        (first_y),
		.az        (first_z),
		.bx        (second_x),
		.by        (second_y),
		.bz        (second_z),
		.valid_out (valid_s3),
		.tag_out   (tag_s3),
		.dist_perp (dist_perp_s3),
		.dist_para (dist_para_s3)
	);

	gce_lookup u_look_perp (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s3),
		.dist_sq   (dist_perp_s3),
		.scale     (perp_scale_q),
		.valid_out (valid_perp_s8),
		.g         (g_perp_s8)
	);

	gce_lookup u_look_para (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s3),
		.dist_sq   (dist_para_s3),
		.scale     (para_scale_q),
		.valid_out (valid_para_s8),
		.g         (g_para_s8)
	);

	// The item tag waits alongside the two lookups.
	always_ff @(posedge clk) begin
		tag_s4 <= tag_s3;
		tag_s5 <= tag_s4;
		tag_s6 <= tag_s5;
		tag_s7 <= tag_s6;
		tag_s8 <= tag_s7;
	end

	gce_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (valid_perp_s8),
		.tag_in     (tag_s8),
		.g_perp     (g_perp_s8),
		.g_para     (g_para_s8),
		.variance   (variance_q),
		.done       (done),
		.covariance (covariance)
	);

	// Both lookups run in lockstep on the same item.
	a_lookup_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_perp_s8 == valid_para_s8)
		else $error("perpendicular and parallel lookups out of step");

	// Every accepted item yields a result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(gce_pkg::PIPE_LATENCY) done)
		else $error("accepted item produced no result");

	// No result appears without an item taken at the matching edge.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, gce_pkg::PIPE_LATENCY))
		else $error("result without a matching item");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gaussian covariance element. Items go in
// through the start/busy command port, each covariance coming back on done is
// checked in order against a bit-exact prediction, and the three configuration
// registers are swept through zero, full scale and random settings between
// drained phases.
// ----------------------------------------------------------------------------
module tb_top;
	import gce_pkg::*;

	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 153;
	localparam int WATCHDOG_LIMIT  = 1000;

	localparam logic [1:0]           REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [COORD_W-1:0]   COORD_MAX  = '1;
	localparam logic [INDEX_W-1:0]   INDEX_MAX  = '1;
	localparam logic [REG_W-1:0]     REG_MAX    = '1;
	localparam logic [OUT_W-1:0]     COV_MAX    = '1;
	localparam logic [REG_W-1:0]     WEIGHT_ONE = 24'd65536;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [INDEX_W-1:0] first_index;
		logic [INDEX_W-1:0] second_index;
		logic [COORD_W-1:0] first_x;
		logic [COORD_W-1:0] first_y;
		logic [COORD_W-1:0] first_z;
		logic [COORD_W-1:0] second_x;
		logic [COORD_W-1:0] second_y;
		logic [COORD_W-1:0] second_z;
		logic [REG_W-1:0]   pixel_weight;
	} request_t;

	// Scoreboard: computes the covariance of each accepted item and keeps the
	// values in arrival order until the block answers them.
	class covariance_scoreboard;
		bit [G_W-1:0]     decay [TABLE_SIZE];
		bit [REG_W-1:0]   perp_scale;
		bit [REG_W-1:0]   para_scale;
		bit [REG_W-1:0]   variance;
		logic [OUT_W-1:0] expected_covariance [$];
		int               errors;

		// Builds exp(-k/steps) by repeated multiplication with a Taylor base.
		function new();
			bit [63:0] term;
			bit [63:0] series;
			bit [63:0] base;
			bit [63:0] level;
			bit [63:0] entry;
			series = 64'd1 << 62;
			term = series;
			for (int n = 1; n <= 24; n++) begin
				term = term / (64'(STEPS_PER_UNIT) * 64'(n));
				if (n % 2)
					series = series - term;
				else
					series = series + term;
			end
			base = (series + (64'd1 << 29)) >> 30;
			if (base > 64'hFFFF_FFFF)
				base = 64'hFFFF_FFFF;
			level = 64'd1 << 32;
			for (int k = 0; k < TABLE_SIZE; k++) begin
				entry = (level + 64'd32768) >> 16;
				decay[k] = (entry > 64'd65535) ? 16'hFFFF : entry[15:0];
				level = (level * base + (64'd1 << 31)) >> 32;
			end
			perp_scale = CFG_RESET;
			para_scale = CFG_RESET;
			variance = CFG_RESET;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
			case (idx)
				CFG_PERP_SCALE:      perp_scale = value;
				CFG_PARA_SCALE:      para_scale = value;
				CFG_SIGNAL_VARIANCE: variance = value;
				default: ;
			endcase
		endfunction

		// Interpolated decay at a scaled squared separation; zero past the table.
		function bit [63:0] decay_at(bit [63:0] dist_sq, bit [63:0] scale);
			bit [63:0] pos;
			bit [63:0] idx;
			bit [63:0] frac;
			pos = (dist_sq >> 16) * scale + (((dist_sq & 64'hFFFF) * scale) >> 16);
			idx = pos >> 16;
			frac = pos & 64'hFFFF;
			if (idx > 64'(TABLE_SIZE - 2))
				return 64'd0;
			return (64'(decay[idx]) * (64'd65536 - frac) +
				64'(decay[idx + 1]) * frac + 64'd32768) >> 16;
		endfunction

		function bit [63:0] separation(bit [COORD_W-1:0] a, bit [COORD_W-1:0] b);
			return (a > b) ? 64'(a - b) : 64'(b - a);
		endfunction

		function logic [OUT_W-1:0] predict_covariance(request_t r);
			bit [63:0] dx;
			bit [63:0] dy;
			bit [63:0] dz;
			bit [63:0] g_perp;
			bit [63:0] g_para;
			bit [63:0] product;
			bit [63:0] weighted;
			bit [63:0] total;
			dx = separation(r.first_x, r.second_x);
			dy = separation(r.first_y, r.second_y);
			dz = separation(r.first_z, r.second_z);
			g_perp = decay_at(dx * dx + dy * dy, 64'(perp_scale));
			g_para = decay_at(dz * dz, 64'(para_scale));
			product = (64'(variance) * g_perp + 64'd32768) >> 16;
			product = (product * g_para + 64'd32768) >> 16;
			weighted = (64'(r.pixel_weight) * product + 64'd32768) >> 16;
			case (r.req_type)
				REQ_DATA_DATA: total = (r.first_index == r.second_index) ?
					weighted + 64'd65536 : product;
				REQ_MAP_DATA:  total = product;
				REQ_DATA_MAP:  total = weighted;
				default:       total = 64'd0;
			endcase
			if (total > 64'(COV_MAX))
				total = 64'(COV_MAX);
			return total[OUT_W-1:0];
		endfunction

		function void note_request(request_t r);
			expected_covariance.push_back(predict_covariance(r));
		endfunction

		function void check_covariance(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			if (expected_covariance.size() == 0) begin
				$display("%0t: covariance expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = expected_covariance.pop_front();
			if (got !== want) begin
				$display("%0t: covariance expected %h, got %h", $time, want, got);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_covariance.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         req_type;
	logic [INDEX_W-1:0] first_index;
	logic [INDEX_W-1:0] second_index;
	logic [COORD_W-1:0] first_x;
	logic [COORD_W-1:0] first_y;
	logic [COORD_W-1:0] first_z;
	logic [COORD_W-1:0] second_x;
	logic [COORD_W-1:0] second_y;
	logic [COORD_W-1:0] second_z;
	logic [REG_W-1:0]   pixel_weight;
	logic               cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]   cfg_data;
	logic               done;
	logic [OUT_W-1:0]   covariance;

	covariance_scoreboard board;
	int                   idle_cycles;

	gaussian_covariance_element_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.first_index  (first_index),
		.second_index (second_index),
		.first_x      (first_x),
		.first_y      (first_y),
		.first_z      (first_z),
		.second_x     (second_x),
		.second_y     (second_y),
		.second_z     (second_z),
		.pixel_weight (pixel_weight),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.covariance   (covariance)
	);

	always #4 clk = ~clk;

	// Every strobed covariance is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			board.check_covariance(covariance);
	end

	// Watchdog: ends the run when neither side moves anything for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || done === 1'b1 || (start && busy === 1'b0)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("gaussian_covariance_element_core: mismatch");
				$finish;
			end
		end
	end

	function automatic request_t make_request(logic [1:0] kind,
		logic [INDEX_W-1:0] row, logic [INDEX_W-1:0] col,
		logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay, logic [COORD_W-1:0] az,
		logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by, logic [COORD_W-1:0] bz,
		logic [REG_W-1:0] weight);
		request_t r;
		r.req_type = kind;
		r.first_index = row;
		r.second_index = col;
		r.first_x = ax;
		r.first_y = ay;
		r.first_z = az;
		r.second_x = bx;
		r.second_y = by;
		r.second_z = bz;
		r.pixel_weight = weight;
		return r;
	endfunction

	// Second coordinate near the first so that most lookups land in the table.
	function automatic logic [COORD_W-1:0] nearby_coord(logic [COORD_W-1:0] base);
		int     pick;
		longint offset;
		longint c;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			offset = 0;
		else if (pick < 35)
			offset = $urandom_range(1, 63);
		else if (pick < 70)
			offset = $urandom_range(64, 2047);
		else if (pick < 90)
			offset = $urandom_range(2048, 16383);
		else
			return COORD_W'($urandom);
		if ($urandom_range(0, 1))
			c = longint'(base) + offset;
		else
			c = longint'(base) - offset;
		if (c < 0)
			c = longint'(base) + offset;
		if (c > longint'(COORD_MAX))
			c = longint'(base) - offset;
		return COORD_W'(c);
	endfunction

	function automatic request_t random_request();
		request_t r;
		r.req_type = ($urandom_range(0, 19) == 0) ? REQ_UNUSED : 2'($urandom_range(0, 2));
		r.first_index = INDEX_W'($urandom);
		r.second_index = ($urandom_range(0, 9) < 4) ? r.first_index : INDEX_W'($urandom);
		r.first_x = COORD_W'($urandom);
		r.first_y = COORD_W'($urandom);
		r.first_z = COORD_W'($urandom);
		r.second_x = nearby_coord(r.first_x);
		r.second_y = nearby_coord(r.first_y);
		r.second_z = nearby_coord(r.first_z);
		case ($urandom_range(0, 9))
			0:       r.pixel_weight = '0;
			1:       r.pixel_weight = REG_MAX;
			2:       r.pixel_weight = WEIGHT_ONE;
			default: r.pixel_weight = REG_W'($urandom);
		endcase
		return r;
	endfunction

	function automatic logic [REG_W-1:0] random_setting();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return REG_MAX;
			2, 3:    return REG_W'(65536 + $urandom_range(0, 8192) - 4096);
			4, 5:    return REG_W'($urandom_range(0, 65536));
			6, 7:    return REG_W'($urandom_range(0, 1048575));
			default: return REG_W'($urandom);
		endcase
	endfunction

	function automatic int random_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		else if (pick < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Presents one item and waits for the edge that takes it.
	task automatic send_request(input request_t r);
		@(negedge clk);
		req_type = r.req_type;
		first_index = r.first_index;
		second_index = r.second_index;
		first_x = r.first_x;
		first_y = r.first_y;
		first_z = r.first_z;
		second_x = r.second_x;
		second_y = r.second_y;
		second_z = r.second_z;
		pixel_weight = r.pixel_weight;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		board.note_request(r);
	endtask

	// Holds start low for the given number of cycles while some fields carry junk.
	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start = 1'b0;
			{req_type, first_index, second_index} = 34'({$urandom, $urandom});
			first_x = COORD_W'($urandom);
			second_z = COORD_W'($urandom);
			pixel_weight = REG_W'($urandom);
		end
	endtask

	// Stops sending and waits for every predicted covariance to come back.
	task automatic drain_pipeline();
		@(negedge clk);
		start = 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [REG_W-1:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 1'b0;
		board.write_register(idx, value);
	endtask

	initial begin
		bit burst;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_DATA_DATA;
		first_index = '0;
		second_index = '0;
		first_x = '0;
		first_y = '0;
		first_z = '0;
		second_x = '0;
		second_y = '0;
		second_z = '0;
		pixel_weight = '0;
		cfg_write = 1'b0;
		cfg_index = CFG_PERP_SCALE;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items at the reset settings: every request type, the
		// diagonal and off-diagonal data-data cases, field extremes and
		// separations on both sides of the last interpolation interval.
		send_request(make_request(REQ_DATA_DATA, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_DATA_DATA, INDEX_MAX, INDEX_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, REG_MAX));
		send_request(make_request(REQ_DATA_DATA, 5, 6, 100, 200, 300, 100, 200, 300,
			REG_MAX));
		send_request(make_request(REQ_MAP_DATA, 0, INDEX_MAX, 0, 0, 0, 256, 0, 0,
			WEIGHT_ONE));
		send_request(make_request(REQ_DATA_MAP, INDEX_MAX, 0, 0, 0, 0, 0, 256, 0,
			24'h8000));
		send_request(make_request(REQ_UNUSED, 1, 1, 0, 0, 0, 0, 0, 0, REG_MAX));
		send_request(make_request(REQ_MAP_DATA, 2, 3, COORD_MAX, COORD_MAX, COORD_MAX,
			0, 0, 0, REG_MAX));
		send_request(make_request(REQ_MAP_DATA, 7, 8, 8184, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_MAP_DATA, 7, 8, 8188, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_DATA_MAP, 9, 9, 0, 0, 0, 0, 0, 8184, REG_MAX));
		send_request(make_request(REQ_DATA_MAP, 9, 9, 0, 0, 8192, 0, 0, 0, REG_MAX));
		send_request(make_request(REQ_MAP_DATA, 4, 4, 1, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_DATA_DATA, 77, 77, 5000, 5000, 0, 0, 0, 0,
			WEIGHT_ONE));
		send_request(make_request(REQ_MAP_DATA, 3, 4, 300, 8184, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_DATA_MAP, 3, 4, 20'h80000, 20'h80000, 20'h80000,
			20'h80100, 20'h7FF00, 20'h80040, 0));
		send_request(make_request(REQ_DATA_DATA, 12, 12, 20'h55555, 20'hAAAAA,
			20'h55555, 20'h55555, 20'hAAAAA, 20'h55555, REG_MAX));

		// Random phases, each under its own register settings.
		for (int p = 0; p < PHASES; p++) begin
			drain_pipeline();
			if (p == 0) begin
				write_register(CFG_PERP_SCALE, '0);
				write_register(CFG_PARA_SCALE, '0);
				write_register(CFG_SIGNAL_VARIANCE, '0);
			end else if (p == 1) begin
				write_register(CFG_PERP_SCALE, REG_MAX);
				write_register(CFG_PARA_SCALE, REG_MAX);
				write_register(CFG_SIGNAL_VARIANCE, REG_MAX);
			end else begin
				write_register(CFG_PERP_SCALE, random_setting());
				write_register(CFG_PARA_SCALE, random_setting());
				write_register(CFG_SIGNAL_VARIANCE, random_setting());
				if (p == 2)
					write_register(CFG_UNUSED, REG_W'($urandom));
			end
			burst = ($urandom_range(0, 2) == 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				idle_sender(burst ? 0 : random_gap());
				send_request(random_request());
			end
		end

		drain_pipeline();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("gaussian_covariance_element_core: match");
		else
			$display("gaussian_covariance_element_core: mismatch");
		$finish;
	end

endmodule
